@@ hdl/dbwc_pkg.sv @@
// dbwc_pkg: widths, register indexes, reset values and shared types of the
// delay-based window controller
// depends on nothing; every other file of the block uses it
package dbwc_pkg;

    localparam int TIME_W     = 40;
    localparam int ONE_WAY_W  = TIME_W + 1;
    localparam int WIN_W      = 16;
    localparam int STEP_W     = 8;
    localparam int RATIO_W    = 10;
    localparam int DGRAM_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INCREASE_STEP  = 3'd0,
        REG_DECREASE_STEP  = 3'd1,
        REG_DELAY_RATIO    = 3'd2,
        REG_WINDOW_FLOOR   = 3'd3,
        REG_WINDOW_CEILING = 3'd4
    } dbwc_reg_idx_t;

    localparam logic [STEP_W-1:0]  RST_INCREASE_STEP  = 8'd128;
    localparam logic [STEP_W-1:0]  RST_DECREASE_STEP  = 8'd77;
    localparam logic [RATIO_W-1:0] RST_DELAY_RATIO    = 10'd358;
    localparam logic [DGRAM_W-1:0] RST_WINDOW_FLOOR   = 8'd1;
    localparam logic [DGRAM_W-1:0] RST_WINDOW_CEILING = 8'd70;

    localparam logic [WIN_W-1:0]     RST_WINDOW_Q8      = 16'd256;
    // largest positive 41-bit two's complement value
    localparam logic [ONE_WAY_W-1:0] RST_MIN_ONE_WAY    = {1'b0, {TIME_W{1'b1}}};
    localparam logic [TIME_W-1:0]    RST_MIN_ROUND_TRIP = {TIME_W{1'b1}};

    typedef struct packed {
        logic [STEP_W-1:0]  increase_step;
        logic [STEP_W-1:0]  decrease_step;
        logic [RATIO_W-1:0] delay_ratio;
        logic [DGRAM_W-1:0] window_floor;
        logic [DGRAM_W-1:0] window_ceiling;
    } dbwc_cfg_t;

    typedef struct packed {
        logic [WIN_W-1:0]     window_q8;
        logic [ONE_WAY_W-1:0] min_one_way;   // two's complement
        logic [TIME_W-1:0]    min_round_trip;
    } dbwc_state_t;

endpackage

@@ hdl/dbwc_if.sv @@
// dbwc channel interfaces: ack input, window result and register write
// depends on dbwc_pkg for widths
interface dbwc_ack_if;
    logic                        valid;
    logic                        ready;
    logic [dbwc_pkg::TIME_W-1:0] sent_time;
    logic [dbwc_pkg::TIME_W-1:0] arrival_time;
    logic [dbwc_pkg::TIME_W-1:0] ack_time;

    modport source (output valid, output sent_time, output arrival_time,
                    output ack_time, input ready);
    modport sink (input valid, input sent_time, input arrival_time,
                  input ack_time, output ready);
endinterface

interface dbwc_win_if;
    logic                         valid;
    logic                         ready;
    logic [dbwc_pkg::DGRAM_W-1:0] window_datagrams;
    logic [dbwc_pkg::WIN_W-1:0]   window_fixed;
    logic                         congested;

    modport source (output valid, output window_datagrams, output window_fixed,
                    output congested, input ready);
    modport sink (input valid, input window_datagrams, input window_fixed,
                  input congested, output ready);
endinterface

interface dbwc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dbwc_pkg::CFG_IDX_W-1:0]  index;
    logic [dbwc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/delay_based_window_controller_unit.sv @@
// delay_based_window_controller_unit: top level of the delay-based window
// controller; holds config, controller state, input and result registers
// depends on dbwc_pkg, dbwc_if and dbwc_update
//
// usage:
//  - ack channel: one beat per acknowledgement, carrying sent, arrival and
//    ack timestamps in ms; a beat is taken when valid and ready are high
//  - win channel: one beat per ack with the new window (whole datagrams and
//    q8.8) and a flag that the ack was judged congested
//  - cfg channel: register writes (index, data), always ready; only the
//    register's width of data is kept, unknown indices are dropped; write
//    only while no ack is in flight
//  - an ack goes from the input register to the result register, which then
//    shows it as a valid beat; one ack per cycle while win is not stalled, set by
//    the combinational state update (minima, 40x10 threshold multiply, compare, window step)
//  - a stalled receiver holds the result register; the input register still
//    takes one more ack, then ready drops until the result beat leaves
//  - reset: config returns to its defaults, window to one datagram, both
//    delay minima to their largest values, both stages empty
module delay_based_window_controller_unit (
    input logic     clk,
    input logic     rst_n,
    dbwc_cfg_if.sink   cfg,
    dbwc_ack_if.sink   ack,
    dbwc_win_if.source win
);
    import dbwc_pkg::*;

    dbwc_cfg_t   cfg_reg;
    dbwc_state_t state_reg;
    dbwc_state_t state_next;

    // input stage
    logic              in_valid_reg;
    logic [TIME_W-1:0] sent_reg;
    logic [TIME_W-1:0] arrival_reg;
    logic [TIME_W-1:0] ack_reg;

    // result stage
    logic             out_valid_reg;
    logic [WIN_W-1:0] window_reg;
    logic             congested_reg;

    logic advance;
    logic update;
    logic congested;

    // result register free or emptying this cycle
    assign advance   = !out_valid_reg || win.ready;
    assign update    = in_valid_reg && advance;
    assign ack.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.increase_step  <= RST_INCREASE_STEP;
            cfg_reg.decrease_step  <= RST_DECREASE_STEP;
            cfg_reg.delay_ratio    <= RST_DELAY_RATIO;
            cfg_reg.window_floor   <= RST_WINDOW_FLOOR;
            cfg_reg.window_ceiling <= RST_WINDOW_CEILING;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_INCREASE_STEP:  cfg_reg.increase_step  <= cfg.data[STEP_W-1:0];
                REG_DECREASE_STEP:  cfg_reg.decrease_step  <= cfg.data[STEP_W-1:0];
                REG_DELAY_RATIO:    cfg_reg.delay_ratio    <= cfg.data[RATIO_W-1:0];
                REG_WINDOW_FLOOR:   cfg_reg.window_floor   <= cfg.data[DGRAM_W-1:0];
                REG_WINDOW_CEILING: cfg_reg.window_ceiling <= cfg.data[DGRAM_W-1:0];
                default:            ;
            endcase
        end
    end

    // input register: takes a beat whenever its content moves on or it is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (ack.ready)
        begin
            in_valid_reg <= ack.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack.valid && ack.ready)
        begin
            sent_reg    <= ack.sent_time;
            arrival_reg <= ack.arrival_time;
            ack_reg     <= ack.ack_time;
        end
    end

    dbwc_update u_update (
        .cfg_regs     (cfg_reg),
        .state        (state_reg),
        .sent_time    (sent_reg),
        .arrival_time (arrival_reg),
        .ack_time     (ack_reg),
        .state_next   (state_next),
        .congested    (congested)
    );

    // controller state moves together with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.window_q8      <= RST_WINDOW_Q8;
            state_reg.min_one_way    <= RST_MIN_ONE_WAY;
            state_reg.min_round_trip <= RST_MIN_ROUND_TRIP;
        end
        else if (update)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            window_reg    <= state_next.window_q8;
            congested_reg <= congested;
        end
    end

    assign win.valid            = out_valid_reg;
    assign win.window_fixed     = window_reg;
    assign win.window_datagrams = window_reg[WIN_W-1:WIN_W-DGRAM_W];
    assign win.congested        = congested_reg;

`ifndef SYNTH
    // round-trip minimum only ever falls
    a_min_rt_falls: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> state_reg.min_round_trip <= $past(state_reg.min_round_trip))
        else $error("round-trip minimum rose");

    // one-way minimum only ever falls
    a_min_ow_falls: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> $signed(state_reg.min_one_way) <= $signed($past(state_reg.min_one_way)))
        else $error("one-way minimum rose");

    // a shown result is always the current window
    a_result_is_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> win.window_fixed == state_reg.window_q8)
        else $error("result window differs from controller state");

    // a full pipe under stall keeps both stages
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !win.ready |=> in_valid_reg && out_valid_reg)
        else $error("beat lost under stall");
`endif

endmodule

@@ hdl/dbwc_update.sv @@
// dbwc_update: one ack's delay estimate, congestion test and window step
// purely combinational; depends on dbwc_pkg
module dbwc_update (
    input  dbwc_pkg::dbwc_cfg_t              cfg_regs,
    input  dbwc_pkg::dbwc_state_t            state,
    input  logic [dbwc_pkg::TIME_W-1:0]      sent_time,
    input  logic [dbwc_pkg::TIME_W-1:0]      arrival_time,
    input  logic [dbwc_pkg::TIME_W-1:0]      ack_time,
    output dbwc_pkg::dbwc_state_t            state_next,
    output logic                             congested
);
    import dbwc_pkg::*;

    localparam int PROD_W = TIME_W + RATIO_W;
    localparam int CMP_W  = PROD_W + 1;
    localparam int W_W    = WIN_W + 2;

    logic [ONE_WAY_W-1:0] one_way;
    logic [TIME_W-1:0]    round_trip;
    logic [ONE_WAY_W-1:0] min_ow;
    logic [TIME_W-1:0]    min_rt;
    logic [ONE_WAY_W:0]   excess_wide;
    logic [ONE_WAY_W-1:0] excess;
    logic [PROD_W-1:0]    threshold;
    logic [CMP_W-1:0]     estimate;
    logic signed [W_W-1:0] w_step;
    logic signed [W_W-1:0] w_lo;
    logic signed [W_W-1:0] w_hi;
    logic signed [W_W-1:0] w_clamp;

    always_comb
    begin
        // arrival may precede sent: keep the sign in bit 40
        one_way    = {1'b0, arrival_time} - {1'b0, sent_time};
        round_trip = ack_time - sent_time;

        min_ow = ($signed(one_way) < $signed(state.min_one_way)) ? one_way
                                                                 : state.min_one_way;
        min_rt = (round_trip < state.min_round_trip) ? round_trip
                                                     : state.min_round_trip;

        // never negative since the minimum was taken first
        excess_wide = {one_way[ONE_WAY_W-1], one_way} - {min_ow[ONE_WAY_W-1], min_ow};
        excess      = excess_wide[ONE_WAY_W-1:0];

        // estimate versus threshold, both scaled by 512
        threshold = PROD_W'(min_rt) * PROD_W'(cfg_regs.delay_ratio);
        estimate  = CMP_W'({min_rt, 8'd0}) + CMP_W'({excess, 9'd0});
        congested = estimate > CMP_W'(threshold);

        if (congested)
        begin
            w_step = $signed(W_W'(state.window_q8)) - $signed(W_W'(cfg_regs.decrease_step));
        end
        else
        begin
            w_step = $signed(W_W'(state.window_q8)) + $signed(W_W'(cfg_regs.increase_step));
        end

        w_lo = $signed(W_W'({cfg_regs.window_floor, 8'd0}));
        w_hi = $signed(W_W'({cfg_regs.window_ceiling, 8'd0}));

        // when floor and ceiling cross, a step below the floor goes to the floor, any other to the ceiling
        if (w_step < w_lo)
        begin
            w_clamp = w_lo;
        end
        else if (w_step > w_hi)
        begin
            w_clamp = w_hi;
        end
        else
        begin
            w_clamp = w_step;
        end
        if (w_clamp < $signed(W_W'(0)))
        begin
            w_clamp = '0;
        end

        state_next.window_q8      = w_clamp[WIN_W-1:0];
        state_next.min_one_way    = min_ow;
        state_next.min_round_trip = min_rt;
    end

endmodule
